@@ src/dess_pkg.sv @@
`default_nettype none

package dess_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_MODIFY = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Microprogram step addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_D_PUSH   = 4'd1;  // dispatch table base
  localparam logic [STEP_W-1:0] STEP_D_POP    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_D_PEEK   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_D_MODIFY = 4'd4;
  localparam logic [STEP_W-1:0] STEP_D_OVF    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_D_EPOP   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_D_EPEEK  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_D_EMOD   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_PEEK_OUT = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SCAN_CMP = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SCAN_ADV = 4'd11;
  localparam logic [STEP_W-1:0] STEP_NOTFOUND = 4'd12;
  localparam logic [STEP_W-1:0] STEP_FOUND    = 4'd13;
  localparam logic [STEP_W-1:0] STEP_SCAN_RD  = 4'd14;

  // Datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_PUSH  = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;
  localparam logic [2:0] OP_WRNEW = 3'd5;
  localparam logic [2:0] OP_INC   = 3'd6;

  // Jump conditions
  localparam logic [1:0] C_ALWAYS = 2'd0;
  localparam logic [1:0] C_MATCH  = 2'd1;
  localparam logic [1:0] C_MORE   = 2'd2;
  localparam logic [1:0] C_NEVER  = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic              which_stack;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } dess_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [3:0]         position;
  } dess_out_t;

  // One control word of the microprogram
  typedef struct packed {
    logic [2:0]        op;
    logic              disp;      // multiway jump on command and error flag
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
    logic              emit;
    logic [1:0]        st;
    logic              use_data;
  } dess_uword_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic bad;     // incoming command fails (full on push, empty otherwise)
    logic match;   // scanned entry equals the search value
    logic more;    // scan index has not reached the last occupied entry
  } dess_flags_t;

endpackage

`default_nettype wire

@@ src/dess_useq.sv @@
`default_nettype none

module dess_useq
  import dess_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  command,
  input  wire dess_flags_t flags,
  output dess_uword_t      ctrl,
  output logic             busy
);

  logic [STEP_W-1:0] upc_r;
  logic [STEP_W-1:0] upc_nxt;
  dess_uword_t       uw;
  logic              cond_true;

  function automatic dess_uword_t mk(input logic [2:0] op, input logic disp,
                                     input logic [1:0] cond,
                                     input logic [STEP_W-1:0] target,
                                     input logic emit, input logic [1:0] st,
                                     input logic use_data);
    dess_uword_t w;
    w.op       = op;
    w.disp     = disp;
    w.cond     = cond;
    w.target   = target;
    w.emit     = emit;
    w.st       = st;
    w.use_data = use_data;
    return w;
  endfunction

  // Microcode ROM
  always_comb begin
    case (upc_r)
      STEP_IDLE:     uw = mk(OP_LOAD,  1'b1, C_NEVER,  STEP_IDLE,     1'b0, ST_OK, 1'b0);
      STEP_D_PUSH:   uw = mk(OP_PUSH,  1'b0, C_ALWAYS, STEP_IDLE,     1'b1, ST_OK, 1'b0);
      STEP_D_POP:    uw = mk(OP_POP,   1'b0, C_ALWAYS, STEP_IDLE,     1'b1, ST_OK, 1'b0);
      STEP_D_PEEK:   uw = mk(OP_READ,  1'b0, C_ALWAYS, STEP_PEEK_OUT, 1'b0, ST_OK, 1'b0);
      STEP_D_MODIFY: uw = mk(OP_READ,  1'b0, C_ALWAYS, STEP_SCAN_CMP, 1'b0, ST_OK, 1'b0);
      STEP_D_OVF:    uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE, 1'b1, ST_OVERFLOW, 1'b0);
      STEP_D_EPOP:   uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE, 1'b1, ST_EMPTY, 1'b0);
      STEP_D_EPEEK:  uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE, 1'b1, ST_EMPTY, 1'b0);
      STEP_D_EMOD:   uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE, 1'b1, ST_EMPTY, 1'b0);
      STEP_PEEK_OUT: uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE,     1'b1, ST_OK, 1'b1);
      STEP_SCAN_CMP: uw = mk(OP_NONE,  1'b0, C_MATCH,  STEP_FOUND,    1'b0, ST_OK, 1'b0);
      STEP_SCAN_ADV: uw = mk(OP_INC,   1'b0, C_MORE,   STEP_SCAN_RD,  1'b0, ST_OK, 1'b0);
      STEP_NOTFOUND: uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE, 1'b1, ST_NOTFOUND, 1'b0);
      STEP_FOUND:    uw = mk(OP_WRNEW, 1'b0, C_ALWAYS, STEP_IDLE,     1'b1, ST_OK, 1'b0);
      STEP_SCAN_RD:  uw = mk(OP_READ,  1'b0, C_ALWAYS, STEP_SCAN_CMP, 1'b0, ST_OK, 1'b0);
      default:       uw = mk(OP_NONE,  1'b0, C_ALWAYS, STEP_IDLE,     1'b0, ST_OK, 1'b0);
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      C_ALWAYS: cond_true = 1'b1;
      C_MATCH:  cond_true = flags.match;
      C_MORE:   cond_true = flags.more;
      default:  cond_true = 1'b0;
    endcase
  end

  // Select the next step: dispatch on a new transaction, else branch or advance
  always_comb begin
    if (uw.disp) begin
      upc_nxt = start ? (STEP_D_PUSH + {1'b0, flags.bad, command}) : upc_r;
    end else if (cond_true) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign busy = (upc_r != STEP_IDLE);

  // Drop the load unless a transaction is taken
  always_comb begin
    ctrl = uw;
    if (uw.op == OP_LOAD && !start) begin
      ctrl.op = OP_NONE;
    end
  end

endmodule

`default_nettype wire

@@ src/dess_dp.sv @@
`default_nettype none

module dess_dp
  import dess_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dess_uword_t ctrl,
  input  wire dess_in_t    in_item,
  output dess_flags_t      flags,
  output logic             out_valid,
  output dess_out_t        out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (AW > 4) ? AW : 4;
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_M1  = CW'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

  logic signed [31:0] store_r [DEPTH];
  logic signed [31:0] rd_data_r;
  logic               which_r;
  logic signed [31:0] val_r;
  logic signed [31:0] nval_r;
  logic [AW-1:0]      idx_r;
  logic [CW-1:0]      low_cnt_r, low_cnt_nxt;
  logic [CW-1:0]      high_cnt_r, high_cnt_nxt;
  logic               out_valid_r;
  dess_out_t          out_r;

  logic [CW-1:0] in_cnt;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx_calc;
  logic [CW-1:0] low_top;
  logic [AW-1:0] last_idx;
  logic [PW-1:0] idx_wide;

  // Start address and error check for the incoming transaction
  assign in_cnt  = in_item.which_stack ? high_cnt_r : low_cnt_r;
  assign fill    = low_cnt_r + high_cnt_r;
  assign low_top = low_cnt_r - 1'b1;

  always_comb begin
    case (in_item.command)
      CMD_PUSH:   idx_calc = in_item.which_stack ? (DEPTH_M1 - high_cnt_r) : low_cnt_r;
      CMD_POP,
      CMD_PEEK:   idx_calc = in_item.which_stack ? (DEPTH_C - high_cnt_r) : low_top;
      CMD_MODIFY: idx_calc = in_item.which_stack ? (DEPTH_C - high_cnt_r) : '0;
      default:    idx_calc = '0;
    endcase
  end

  assign flags.bad   = (in_item.command == CMD_PUSH) ? (fill == DEPTH_C) : (in_cnt == '0);
  assign flags.match = (rd_data_r == val_r);
  assign last_idx    = which_r ? LAST_IDX : low_top[AW-1:0];
  assign flags.more  = (idx_r != last_idx);

  // Latch the transaction and step the scan index
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_LOAD) begin
      which_r <= in_item.which_stack;
      val_r   <= in_item.value;
      nval_r  <= in_item.new_value;
      idx_r   <= idx_calc[AW-1:0];
    end else if (ctrl.op == OP_INC) begin
      idx_r   <= idx_r + 1'b1;
    end
  end

  // Store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_PUSH:  store_r[idx_r] <= val_r;
      OP_POP:   store_r[idx_r] <= '0;
      OP_WRNEW: store_r[idx_r] <= nval_r;
      OP_READ:  rd_data_r      <= store_r[idx_r];
      default:  ;
    endcase
  end

  // Advance the stack counts
  always_comb begin
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    if (ctrl.op == OP_PUSH) begin
      if (which_r) high_cnt_nxt = high_cnt_r + 1'b1;
      else         low_cnt_nxt  = low_cnt_r + 1'b1;
    end else if (ctrl.op == OP_POP) begin
      if (which_r) high_cnt_nxt = high_cnt_r - 1'b1;
      else         low_cnt_nxt  = low_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      low_cnt_r   <= low_cnt_nxt;
      high_cnt_r  <= high_cnt_nxt;
      out_valid_r <= ctrl.emit;
    end
  end

  // Result register, shown for one cycle
  assign idx_wide = PW'(idx_r);

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_r.status   <= ctrl.st;
      out_r.data     <= ctrl.use_data ? rd_data_r : '0;
      out_r.position <= (ctrl.st == ST_OK) ? idx_wide[3:0] : 4'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

@@ src/double_ended_stack_store.sv @@
// Channel   Ports                      Transaction
// input     start, busy, in_item       start high and busy low at a rising edge
// result    out_valid, out_item        out_valid high for one cycle, always taken
//
// Push, pop and a failed command emit their result from the dispatched step;
// peek reads the store and then emits; modify reads, compares and advances
// entry by entry until a match is found or the last occupied entry is passed;
// the single store port and the compare step of the scan set this sequence.
// A new transaction is accepted in the cycle the result is shown.
// Reset (rst_n low, synchronous) empties both stacks; store contents are
// left as they are. The result side cannot stall.
`default_nettype none

module double_ended_stack_store
  import dess_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dess_in_t in_item,
  output logic          out_valid,
  output dess_out_t     out_item
);

  dess_uword_t ctrl;
  dess_flags_t flags;

  dess_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_item.command),
    .flags   (flags),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  dess_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_item   (in_item),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ src/dess_chk.sv @@
`default_nettype none

module dess_chk
  import dess_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire dess_out_t out_item
);

  // A taken transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepted transaction");

  // Every result follows a busy cycle and ends it
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result without preceding work or while busy");

  // Results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Failed commands carry zero position and zero data
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |->
      out_item.position == 4'd0 && out_item.data == 32'sd0)
    else $error("error result with nonzero position or data");

endmodule

bind double_ended_stack_store dess_chk u_dess_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
